>>> hw/rtl/cnop_pkg.sv
// cnop_pkg: shared types, constants and fixed-point helpers of the
// Crank-Nicolson option pricer. No dependencies.
`default_nettype none
package cnop_pkg;

  localparam int W    = 48;         // value width
  localparam int FRAC = 24;         // fraction bits
  localparam int PW   = W + FRAC;   // width of a shifted product or quotient
  localparam int MAX_HALF_WIDTH_DEF = 128;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = W'(1) << FRAC;

  // configuration register indexes
  localparam logic [2:0] CFG_SPOT   = 3'd0;
  localparam logic [2:0] CFG_STRIKE = 3'd1;
  localparam logic [2:0] CFG_RATIO  = 3'd2;
  localparam logic [2:0] CFG_DISC   = 3'd3;
  localparam logic [2:0] CFG_CL     = 3'd4;
  localparam logic [2:0] CFG_CC     = 3'd5;
  localparam logic [2:0] CFG_CU     = 3'd6;

  typedef enum logic [3:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_DIV, OP_PAYOFF, OP_BLO, OP_BHI
  } op_e;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ONE, SRC_SPOT, SRC_STRIKE, SRC_RATIO, SRC_DISC, SRC_CL, SRC_CC,
    SRC_CU, SRC_VAL, SRC_FAC, SRC_RHS, SRC_S, SRC_INV, SRC_OPB, SRC_DIAG, SRC_LOW,
    SRC_UPP, SRC_KD, SRC_TOP, SRC_LOB, SRC_HIB, SRC_T0, SRC_T1, SRC_PIV, SRC_FPREV,
    SRC_RPREV, SRC_VNEXT
  } src_e;

  typedef enum logic [4:0] {
    DST_NONE, DST_S, DST_INV, DST_OPB, DST_DIAG, DST_LOW, DST_UPP, DST_KD, DST_TOP,
    DST_LOB, DST_HIB, DST_T0, DST_T1, DST_PIV, DST_FPREV, DST_RPREV, DST_VNEXT,
    DST_OUT
  } dst_e;

  typedef enum logic [1:0] {MEM_NONE, MEM_VAL, MEM_FAC, MEM_RHS} mem_e;

  typedef struct packed {
    logic go;     // start the operation this cycle
    logic clr;    // new item: latch option kind, clear divide flag
    op_e  op;
    src_e src_a;
    src_e src_b;
    dst_e dst;
    mem_e wmem;
  } cmd_t;

  typedef struct packed {
    logic done;   // operation result written
  } dp_sts_t;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    mag = a[W-1] ? W'(-a) : W'(a);
  endfunction

  // apply sign to a magnitude and saturate to the value range
  function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic [PW-1:0] p);
    logic [PW-1:0] lim_neg;
    logic [PW-1:0] lim_pos;
    lim_neg = PW'(1) << (W-1);
    lim_pos = lim_neg - PW'(1);
    if (neg) begin
      sat_mag = (p > lim_neg) ? MINV : -$signed(p[W-1:0]);
    end else begin
      sat_mag = (p > lim_pos) ? MAXV : $signed(p[W-1:0]);
    end
  endfunction

  function automatic logic signed [W-1:0] addq(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) addq = s[W] ? MINV : MAXV;
    else addq = s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] subq(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) subq = s[W] ? MINV : MAXV;
    else subq = s[W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cnop_mul.sv
// cnop_mul: multi-cycle signed Q24.24 multiplier, 48x16 partial product per cycle.
// Depends on cnop_pkg.
`default_nettype none
module cnop_mul (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [cnop_pkg::W-1:0]  a_i,
  input  wire logic signed [cnop_pkg::W-1:0]  b_i,
  output logic                                done_o,
  output logic signed [cnop_pkg::W-1:0]       res_o
);
  localparam int W = cnop_pkg::W;

  logic [W-1:0]   ma_q, mb_q;
  logic [2*W-1:0] acc_q;
  logic [1:0]     cnt_q;
  logic           run_q, neg_q, done_q;
  logic [W+15:0]  prod;

  assign prod = ma_q * mb_q[W-1:W-16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // high chunk of b first; a final step after the last chunk saturates the shifted product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= cnop_pkg::mag(a_i);
      mb_q  <= cnop_pkg::mag(b_i);
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (run_q) begin
      if (cnt_q == 2'd3) begin
        res_o <= cnop_pkg::sat_mag(neg_q, acc_q[2*W-1:cnop_pkg::FRAC]);
      end else begin
        acc_q <= {acc_q[2*W-17:0], 16'b0} + (2*W)'(prod);
        mb_q  <= {mb_q[W-17:0], 16'b0};
      end
    end
  end

  assign done_o = done_q;
endmodule
`default_nettype wire

>>> hw/rtl/cnop_div.sv
// cnop_div: restoring signed Q24.24 divider, one quotient bit per cycle.
// Depends on cnop_pkg.
`default_nettype none
module cnop_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [cnop_pkg::W-1:0]  a_i,
  input  wire logic signed [cnop_pkg::W-1:0]  b_i,
  output logic                                done_o,
  output logic                                dz_o,
  output logic signed [cnop_pkg::W-1:0]       res_o
);
  localparam int W  = cnop_pkg::W;
  localparam int PW = cnop_pkg::PW;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] num_q, q_q;
  logic [W-1:0]  rem_q, mb_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, fin_q, done_q, dz_q, neg_q;
  logic [W:0]    r2;
  logic          ge;

  assign r2 = {rem_q, num_q[PW-1]};
  assign ge = r2 >= {1'b0, mb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      dz_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      dz_q   <= 1'b0;
      if (start_i) begin
        if (b_i == '0) begin
          done_q <= 1'b1;
          dz_q   <= 1'b1;
        end else begin
          run_q <= 1'b1;
          cnt_q <= CW'(PW - 1);
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {cnop_pkg::mag(a_i), {cnop_pkg::FRAC{1'b0}}};
      mb_q  <= cnop_pkg::mag(b_i);
      neg_q <= a_i[W-1] ^ b_i[W-1];
      rem_q <= '0;
      q_q   <= '0;
      // divide by zero: saturate toward the dividend's sign
      if (a_i[W-1]) res_o <= cnop_pkg::MINV;
      else if (a_i != '0) res_o <= cnop_pkg::MAXV;
      else res_o <= '0;
    end else if (run_q) begin
      rem_q <= ge ? W'(r2 - {1'b0, mb_q}) : W'(r2);
      q_q   <= {q_q[PW-2:0], ge};
      num_q <= {num_q[PW-2:0], 1'b0};
    end else if (fin_q) begin
      res_o <= cnop_pkg::sat_mag(neg_q, q_q);
    end
  end

  assign done_o = done_q;
  assign dz_o   = dz_q;
endmodule
`default_nettype wire

>>> hw/rtl/cnop_dp.sv
// cnop_dp: pricer datapath: configuration, working registers, row memories,
// combinational ALU and the shared multiplier and divider. Depends on cnop_pkg,
// cnop_mul, cnop_div.
`default_nettype none
module cnop_dp #(
  parameter int MAX_HALF_WIDTH = cnop_pkg::MAX_HALF_WIDTH_DEF,
  localparam int AW = $clog2(2 * MAX_HALF_WIDTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cnop_pkg::cmd_t                cmd_i,
  input  wire logic [AW-1:0]                 addr_i,
  input  wire logic                          is_put_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_idx_i,
  input  wire logic [cnop_pkg::W-1:0]        cfg_wdata_i,
  output cnop_pkg::dp_sts_t                  sts_o,
  output logic signed [cnop_pkg::W-1:0]      price_o,
  output logic                               status_o
);
  localparam int W     = cnop_pkg::W;
  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  typedef logic signed [W-1:0] val_t;

  val_t spot_q, strike_q, ratio_q, disc_q, cl_q, cc_q, cu_q;
  val_t s_q, inv_q, opb_q, diag_q, low_q, upp_q, kd_q, top_q, lob_q, hib_q;
  val_t t0_q, t1_q, piv_q, fprev_q, rprev_q, vnext_q, out_q;
  val_t val_rd_q, fac_rd_q, rhs_rd_q;
  val_t val_mem [DEPTH];
  val_t fac_mem [DEPTH];
  val_t rhs_mem [DEPTH];
  val_t opa, opb, alu_res, pay, wval;
  logic put_q, flag_q, done_q, simple, wen;
  logic mul_done, div_done, div_dz;
  val_t mul_res, div_res;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot_q   <= '0;
      strike_q <= '0;
      ratio_q  <= cnop_pkg::ONE;
      disc_q   <= cnop_pkg::ONE;
      cl_q     <= '0;
      cc_q     <= '0;
      cu_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cnop_pkg::CFG_SPOT:   spot_q   <= {1'b0, cfg_wdata_i[W-2:0]};
        cnop_pkg::CFG_STRIKE: strike_q <= {1'b0, cfg_wdata_i[W-2:0]};
        cnop_pkg::CFG_RATIO:  ratio_q  <= {1'b0, cfg_wdata_i[W-2:0]};
        cnop_pkg::CFG_DISC:   disc_q   <= W'(cfg_wdata_i[24:0]);
        cnop_pkg::CFG_CL:     cl_q     <= cfg_wdata_i;
        cnop_pkg::CFG_CC:     cc_q     <= cfg_wdata_i;
        cnop_pkg::CFG_CU:     cu_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  function automatic val_t pick(input cnop_pkg::src_e s);
    unique case (s)
      cnop_pkg::SRC_ZERO:   pick = '0;
      cnop_pkg::SRC_ONE:    pick = cnop_pkg::ONE;
      cnop_pkg::SRC_SPOT:   pick = spot_q;
      cnop_pkg::SRC_STRIKE: pick = strike_q;
      cnop_pkg::SRC_RATIO:  pick = ratio_q;
      cnop_pkg::SRC_DISC:   pick = disc_q;
      cnop_pkg::SRC_CL:     pick = cl_q;
      cnop_pkg::SRC_CC:     pick = cc_q;
      cnop_pkg::SRC_CU:     pick = cu_q;
      cnop_pkg::SRC_VAL:    pick = val_rd_q;
      cnop_pkg::SRC_FAC:    pick = fac_rd_q;
      cnop_pkg::SRC_RHS:    pick = rhs_rd_q;
      cnop_pkg::SRC_S:      pick = s_q;
      cnop_pkg::SRC_INV:    pick = inv_q;
      cnop_pkg::SRC_OPB:    pick = opb_q;
      cnop_pkg::SRC_DIAG:   pick = diag_q;
      cnop_pkg::SRC_LOW:    pick = low_q;
      cnop_pkg::SRC_UPP:    pick = upp_q;
      cnop_pkg::SRC_KD:     pick = kd_q;
      cnop_pkg::SRC_TOP:    pick = top_q;
      cnop_pkg::SRC_LOB:    pick = lob_q;
      cnop_pkg::SRC_HIB:    pick = hib_q;
      cnop_pkg::SRC_T0:     pick = t0_q;
      cnop_pkg::SRC_T1:     pick = t1_q;
      cnop_pkg::SRC_PIV:    pick = piv_q;
      cnop_pkg::SRC_FPREV:  pick = fprev_q;
      cnop_pkg::SRC_RPREV:  pick = rprev_q;
      cnop_pkg::SRC_VNEXT:  pick = vnext_q;
      default:              pick = '0;
    endcase
  endfunction

  // operand select; re-evaluated whenever any selectable register changes
  always_comb begin
    opa = pick(cmd_i.src_a);
    opb = pick(cmd_i.src_b);
  end

  always_comb begin
    pay = put_q ? cnop_pkg::subq(strike_q, opa) : cnop_pkg::subq(opa, strike_q);
    simple = 1'b1;
    unique case (cmd_i.op)
      cnop_pkg::OP_MOV:    alu_res = opa;
      cnop_pkg::OP_ADD:    alu_res = cnop_pkg::addq(opa, opb);
      cnop_pkg::OP_SUB:    alu_res = cnop_pkg::subq(opa, opb);
      cnop_pkg::OP_NEG:    alu_res = cnop_pkg::subq('0, opa);
      cnop_pkg::OP_PAYOFF: alu_res = pay[W-1] ? '0 : pay;
      cnop_pkg::OP_BLO:    alu_res = put_q ? opa : '0;
      cnop_pkg::OP_BHI:    alu_res = put_q ? '0 : cnop_pkg::subq(opa, opb);
      default: begin
        alu_res = '0;
        simple  = 1'b0;
      end
    endcase
  end

  cnop_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.go && cmd_i.op == cnop_pkg::OP_MUL),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  cnop_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.go && cmd_i.op == cnop_pkg::OP_DIV),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (div_done),
    .dz_o    (div_dz),
    .res_o   (div_res)
  );

  assign wen  = (cmd_i.go && simple) || mul_done || div_done;
  assign wval = mul_done ? mul_res : (div_done ? div_res : alu_res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      put_q  <= 1'b0;
      flag_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= wen;
      if (cmd_i.clr) begin
        put_q  <= is_put_i;
        flag_q <= 1'b0;
      end else if (div_dz) begin
        flag_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      unique case (cmd_i.dst)
        cnop_pkg::DST_S:     s_q     <= wval;
        cnop_pkg::DST_INV:   inv_q   <= wval;
        cnop_pkg::DST_OPB:   opb_q   <= wval;
        cnop_pkg::DST_DIAG:  diag_q  <= wval;
        cnop_pkg::DST_LOW:   low_q   <= wval;
        cnop_pkg::DST_UPP:   upp_q   <= wval;
        cnop_pkg::DST_KD:    kd_q    <= wval;
        cnop_pkg::DST_TOP:   top_q   <= wval;
        cnop_pkg::DST_LOB:   lob_q   <= wval;
        cnop_pkg::DST_HIB:   hib_q   <= wval;
        cnop_pkg::DST_T0:    t0_q    <= wval;
        cnop_pkg::DST_T1:    t1_q    <= wval;
        cnop_pkg::DST_PIV:   piv_q   <= wval;
        cnop_pkg::DST_FPREV: fprev_q <= wval;
        cnop_pkg::DST_RPREV: rprev_q <= wval;
        cnop_pkg::DST_VNEXT: vnext_q <= wval;
        cnop_pkg::DST_OUT:   out_q   <= wval;
        default: ;
      endcase
    end
  end

  // row memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (wen && cmd_i.wmem == cnop_pkg::MEM_VAL) val_mem[addr_i] <= wval;
    if (wen && cmd_i.wmem == cnop_pkg::MEM_FAC) fac_mem[addr_i] <= wval;
    if (wen && cmd_i.wmem == cnop_pkg::MEM_RHS) rhs_mem[addr_i] <= wval;
  end

  always_ff @(posedge clk_i) begin
    val_rd_q <= val_mem[addr_i];
    fac_rd_q <= fac_mem[addr_i];
    rhs_rd_q <= rhs_mem[addr_i];
  end

  assign sts_o.done = done_q;
  assign price_o    = out_q;
  assign status_o   = flag_q;

  mul_div_excl_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");
  done_follows_write_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wen |=> sts_o.done)
    else $error("write not reported as done");
  dz_only_on_done_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_dz |-> div_done)
    else $error("divide-by-zero flag without divider result");
endmodule
`default_nettype wire

>>> hw/rtl/cnop_ctrl.sv
// cnop_ctrl: sequencer of the pricer; steps grid setup, time steps, sweeps
// and back substitution as datapath operations. Depends on cnop_pkg.
`default_nettype none
module cnop_ctrl #(
  parameter int MAX_HALF_WIDTH = cnop_pkg::MAX_HALF_WIDTH_DEF,
  localparam int AW = $clog2(2 * MAX_HALF_WIDTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [11:0]       time_steps_i,
  input  wire logic [7:0]        half_width_i,
  input  wire cnop_pkg::dp_sts_t sts_i,
  output cnop_pkg::cmd_t         cmd_o,
  output logic [AW-1:0]          addr_o,
  output logic                   done_o
);
  localparam int NS = 44;
  localparam int CW = (AW > 8) ? AW : 8;

  typedef enum logic [NS-1:0] {
    S_IDLE = NS'(1) << 0,  S_P0  = NS'(1) << 1,  S_U0  = NS'(1) << 2,
    S_U1   = NS'(1) << 3,  S_TOP = NS'(1) << 4,  S_INV = NS'(1) << 5,
    S_SPOT = NS'(1) << 6,  S_D0  = NS'(1) << 7,  S_D1  = NS'(1) << 8,
    S_OPB  = NS'(1) << 9,  S_DIAG = NS'(1) << 10, S_LOW = NS'(1) << 11,
    S_UPP  = NS'(1) << 12, S_KD0 = NS'(1) << 13, S_K   = NS'(1) << 14,
    S_R0   = NS'(1) << 15, S_R1  = NS'(1) << 16, S_R2  = NS'(1) << 17,
    S_R3   = NS'(1) << 18, S_R4  = NS'(1) << 19, S_BLO = NS'(1) << 20,
    S_BHI  = NS'(1) << 21, S_B2  = NS'(1) << 22, S_B3  = NS'(1) << 23,
    S_B4   = NS'(1) << 24, S_B5  = NS'(1) << 25, S_B6  = NS'(1) << 26,
    S_B7   = NS'(1) << 27, S_F0  = NS'(1) << 28, S_F1  = NS'(1) << 29,
    S_F2   = NS'(1) << 30, S_F3  = NS'(1) << 31, S_F4  = NS'(1) << 32,
    S_F5   = NS'(1) << 33, S_F6  = NS'(1) << 34, S_F7  = NS'(1) << 35,
    S_F8   = NS'(1) << 36, S_BV  = NS'(1) << 37, S_G0  = NS'(1) << 38,
    S_G1   = NS'(1) << 39, S_E0  = NS'(1) << 40, S_E1  = NS'(1) << 41,
    S_FIN  = NS'(1) << 42, S_OUT = NS'(1) << 43
  } state_e;

  typedef enum logic [1:0] {PH_ADDR, PH_GO, PH_WAIT} phase_e;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [AW-1:0] j_q, j_d, m_q, m_d, last_q, last_d;
  logic [11:0]   n_q, n_d, step_q, step_d;
  logic [CW-1:0] hw;
  logic          adv, active;

  assign hw     = CW'(half_width_i);
  assign active = (state_q != S_IDLE) && (state_q != S_OUT);
  assign adv    = (ph_q == PH_WAIT) && sts_i.done;

  // operation of each state
  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = cnop_pkg::OP_MOV;
    cmd_o.src_a = cnop_pkg::SRC_ZERO;
    cmd_o.src_b = cnop_pkg::SRC_ZERO;
    cmd_o.dst   = cnop_pkg::DST_NONE;
    cmd_o.wmem  = cnop_pkg::MEM_NONE;
    addr_o      = j_q;
    unique case (state_q)
      S_IDLE: cmd_o.clr = start;
      S_P0: begin
        cmd_o.src_a = cnop_pkg::SRC_SPOT; cmd_o.dst = cnop_pkg::DST_S;
      end
      S_U0, S_D0: begin
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_S;
        cmd_o.src_b = (state_q == S_U0) ? cnop_pkg::SRC_RATIO : cnop_pkg::SRC_INV;
        cmd_o.dst = cnop_pkg::DST_S;
      end
      S_U1, S_D1: begin
        cmd_o.op = cnop_pkg::OP_PAYOFF; cmd_o.src_a = cnop_pkg::SRC_S;
        cmd_o.wmem = cnop_pkg::MEM_VAL;
      end
      S_TOP: begin
        cmd_o.src_a = cnop_pkg::SRC_S; cmd_o.dst = cnop_pkg::DST_TOP;
      end
      S_INV: begin
        cmd_o.op = cnop_pkg::OP_DIV; cmd_o.src_a = cnop_pkg::SRC_ONE;
        cmd_o.src_b = cnop_pkg::SRC_RATIO; cmd_o.dst = cnop_pkg::DST_INV;
      end
      S_SPOT: begin
        cmd_o.src_a = cnop_pkg::SRC_SPOT; cmd_o.dst = cnop_pkg::DST_S;
      end
      S_OPB: begin
        cmd_o.op = cnop_pkg::OP_ADD; cmd_o.src_a = cnop_pkg::SRC_ONE;
        cmd_o.src_b = cnop_pkg::SRC_CC; cmd_o.dst = cnop_pkg::DST_OPB;
      end
      S_DIAG: begin
        cmd_o.op = cnop_pkg::OP_SUB; cmd_o.src_a = cnop_pkg::SRC_ONE;
        cmd_o.src_b = cnop_pkg::SRC_CC; cmd_o.dst = cnop_pkg::DST_DIAG;
      end
      S_LOW: begin
        cmd_o.op = cnop_pkg::OP_NEG; cmd_o.src_a = cnop_pkg::SRC_CL;
        cmd_o.dst = cnop_pkg::DST_LOW;
      end
      S_UPP: begin
        cmd_o.op = cnop_pkg::OP_NEG; cmd_o.src_a = cnop_pkg::SRC_CU;
        cmd_o.dst = cnop_pkg::DST_UPP;
      end
      S_KD0: begin
        cmd_o.src_a = cnop_pkg::SRC_STRIKE; cmd_o.dst = cnop_pkg::DST_KD;
      end
      S_K: begin
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_KD;
        cmd_o.src_b = cnop_pkg::SRC_DISC; cmd_o.dst = cnop_pkg::DST_KD;
      end
      S_R0: begin
        addr_o = j_q - AW'(1);
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_CL;
        cmd_o.src_b = cnop_pkg::SRC_VAL; cmd_o.dst = cnop_pkg::DST_T0;
      end
      S_R1: begin
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_OPB;
        cmd_o.src_b = cnop_pkg::SRC_VAL; cmd_o.dst = cnop_pkg::DST_T1;
      end
      S_R2: begin
        cmd_o.op = cnop_pkg::OP_ADD; cmd_o.src_a = cnop_pkg::SRC_T0;
        cmd_o.src_b = cnop_pkg::SRC_T1; cmd_o.dst = cnop_pkg::DST_T0;
      end
      S_R3: begin
        addr_o = j_q + AW'(1);
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_CU;
        cmd_o.src_b = cnop_pkg::SRC_VAL; cmd_o.dst = cnop_pkg::DST_T1;
      end
      S_R4: begin
        cmd_o.op = cnop_pkg::OP_ADD; cmd_o.src_a = cnop_pkg::SRC_T0;
        cmd_o.src_b = cnop_pkg::SRC_T1; cmd_o.wmem = cnop_pkg::MEM_RHS;
      end
      S_BLO: begin
        cmd_o.op = cnop_pkg::OP_BLO; cmd_o.src_a = cnop_pkg::SRC_KD;
        cmd_o.dst = cnop_pkg::DST_LOB;
      end
      S_BHI: begin
        cmd_o.op = cnop_pkg::OP_BHI; cmd_o.src_a = cnop_pkg::SRC_TOP;
        cmd_o.src_b = cnop_pkg::SRC_KD; cmd_o.dst = cnop_pkg::DST_HIB;
      end
      S_B2: begin
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_LOW;
        cmd_o.src_b = cnop_pkg::SRC_LOB; cmd_o.dst = cnop_pkg::DST_T0;
      end
      S_B3, S_F1: begin
        addr_o = AW'(1);
        cmd_o.src_a = cnop_pkg::SRC_RHS; cmd_o.dst = cnop_pkg::DST_T1;
      end
      S_B4: begin
        addr_o = AW'(1);
        cmd_o.op = cnop_pkg::OP_SUB; cmd_o.src_a = cnop_pkg::SRC_T1;
        cmd_o.src_b = cnop_pkg::SRC_T0; cmd_o.wmem = cnop_pkg::MEM_RHS;
      end
      S_B5: begin
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_UPP;
        cmd_o.src_b = cnop_pkg::SRC_HIB; cmd_o.dst = cnop_pkg::DST_T0;
      end
      S_B6: begin
        addr_o = last_q - AW'(1);
        cmd_o.src_a = cnop_pkg::SRC_RHS; cmd_o.dst = cnop_pkg::DST_T1;
      end
      S_B7: begin
        addr_o = last_q - AW'(1);
        cmd_o.op = cnop_pkg::OP_SUB; cmd_o.src_a = cnop_pkg::SRC_T1;
        cmd_o.src_b = cnop_pkg::SRC_T0; cmd_o.wmem = cnop_pkg::MEM_RHS;
      end
      S_F0: begin
        addr_o = AW'(1);
        cmd_o.op = cnop_pkg::OP_DIV; cmd_o.src_a = cnop_pkg::SRC_UPP;
        cmd_o.src_b = cnop_pkg::SRC_DIAG; cmd_o.dst = cnop_pkg::DST_FPREV;
        cmd_o.wmem = cnop_pkg::MEM_FAC;
      end
      S_F2: begin
        addr_o = AW'(1);
        cmd_o.op = cnop_pkg::OP_DIV; cmd_o.src_a = cnop_pkg::SRC_T1;
        cmd_o.src_b = cnop_pkg::SRC_DIAG; cmd_o.dst = cnop_pkg::DST_RPREV;
        cmd_o.wmem = cnop_pkg::MEM_RHS;
      end
      S_F3: begin
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_LOW;
        cmd_o.src_b = cnop_pkg::SRC_FPREV; cmd_o.dst = cnop_pkg::DST_T0;
      end
      S_F4: begin
        cmd_o.op = cnop_pkg::OP_SUB; cmd_o.src_a = cnop_pkg::SRC_DIAG;
        cmd_o.src_b = cnop_pkg::SRC_T0; cmd_o.dst = cnop_pkg::DST_PIV;
      end
      S_F5: begin
        cmd_o.op = cnop_pkg::OP_DIV; cmd_o.src_a = cnop_pkg::SRC_UPP;
        cmd_o.src_b = cnop_pkg::SRC_PIV; cmd_o.dst = cnop_pkg::DST_FPREV;
        cmd_o.wmem = cnop_pkg::MEM_FAC;
      end
      S_F6: begin
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_LOW;
        cmd_o.src_b = cnop_pkg::SRC_RPREV; cmd_o.dst = cnop_pkg::DST_T0;
      end
      S_F7: begin
        cmd_o.op = cnop_pkg::OP_SUB; cmd_o.src_a = cnop_pkg::SRC_RHS;
        cmd_o.src_b = cnop_pkg::SRC_T0; cmd_o.dst = cnop_pkg::DST_T1;
      end
      S_F8: begin
        cmd_o.op = cnop_pkg::OP_DIV; cmd_o.src_a = cnop_pkg::SRC_T1;
        cmd_o.src_b = cnop_pkg::SRC_PIV; cmd_o.dst = cnop_pkg::DST_RPREV;
        cmd_o.wmem = cnop_pkg::MEM_RHS;
      end
      S_BV: begin
        addr_o = last_q - AW'(1);
        cmd_o.src_a = cnop_pkg::SRC_RHS; cmd_o.dst = cnop_pkg::DST_VNEXT;
        cmd_o.wmem = cnop_pkg::MEM_VAL;
      end
      S_G0: begin
        cmd_o.op = cnop_pkg::OP_MUL; cmd_o.src_a = cnop_pkg::SRC_FAC;
        cmd_o.src_b = cnop_pkg::SRC_VNEXT; cmd_o.dst = cnop_pkg::DST_T0;
      end
      S_G1: begin
        cmd_o.op = cnop_pkg::OP_SUB; cmd_o.src_a = cnop_pkg::SRC_RHS;
        cmd_o.src_b = cnop_pkg::SRC_T0; cmd_o.dst = cnop_pkg::DST_VNEXT;
        cmd_o.wmem = cnop_pkg::MEM_VAL;
      end
      S_E0: begin
        addr_o = '0;
        cmd_o.src_a = cnop_pkg::SRC_LOB; cmd_o.wmem = cnop_pkg::MEM_VAL;
      end
      S_E1: begin
        addr_o = last_q;
        cmd_o.src_a = cnop_pkg::SRC_HIB; cmd_o.wmem = cnop_pkg::MEM_VAL;
      end
      S_FIN: begin
        addr_o = m_q;
        cmd_o.src_a = cnop_pkg::SRC_VAL; cmd_o.dst = cnop_pkg::DST_OUT;
      end
      S_OUT: ;
      default: ;
    endcase
    cmd_o.go = active && (ph_q == PH_GO);
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    j_d     = j_q;
    m_d     = m_q;
    last_d  = last_q;
    n_d     = n_q;
    step_d  = step_q;
    if (active) begin
      unique case (ph_q)
        PH_ADDR: ph_d = PH_GO;
        PH_GO:   ph_d = PH_WAIT;
        PH_WAIT: if (adv) ph_d = PH_ADDR;
        default: ph_d = PH_ADDR;
      endcase
    end
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          priority if (hw == '0) m_d = AW'(1);
          else if (hw > CW'(MAX_HALF_WIDTH)) m_d = AW'(MAX_HALF_WIDTH);
          else m_d = AW'(hw);
          last_d  = AW'({m_d, 1'b0});
          j_d     = m_d;
          n_d     = time_steps_i;
          state_d = S_P0;
        end
      end
      S_OUT: state_d = S_IDLE;
      default: begin
        if (adv) begin
          unique case (state_q)
            S_P0:   state_d = S_U1;
            S_U0:   state_d = S_U1;
            S_U1: begin
              if (j_q == last_q) state_d = S_TOP;
              else begin
                j_d = j_q + AW'(1);
                state_d = S_U0;
              end
            end
            S_TOP:  state_d = S_INV;
            S_INV:  state_d = S_SPOT;
            S_SPOT: begin
              j_d = m_q - AW'(1);
              state_d = S_D0;
            end
            S_D0:   state_d = S_D1;
            S_D1: begin
              if (j_q == '0) state_d = S_OPB;
              else begin
                j_d = j_q - AW'(1);
                state_d = S_D0;
              end
            end
            S_OPB:  state_d = S_DIAG;
            S_DIAG: state_d = S_LOW;
            S_LOW:  state_d = S_UPP;
            S_UPP:  state_d = S_KD0;
            S_KD0: begin
              step_d  = '0;
              state_d = (n_q == '0) ? S_FIN : S_K;
            end
            S_K: begin
              j_d = AW'(1);
              state_d = S_R0;
            end
            S_R0: state_d = S_R1;
            S_R1: state_d = S_R2;
            S_R2: state_d = S_R3;
            S_R3: state_d = S_R4;
            S_R4: begin
              if (j_q == last_q - AW'(1)) state_d = S_BLO;
              else begin
                j_d = j_q + AW'(1);
                state_d = S_R0;
              end
            end
            S_BLO: state_d = S_BHI;
            S_BHI: state_d = S_B2;
            S_B2:  state_d = S_B3;
            S_B3:  state_d = S_B4;
            S_B4:  state_d = S_B5;
            S_B5:  state_d = S_B6;
            S_B6:  state_d = S_B7;
            S_B7:  state_d = S_F0;
            S_F0:  state_d = S_F1;
            S_F1:  state_d = S_F2;
            S_F2: begin
              j_d = AW'(2);
              state_d = (last_q == AW'(2)) ? S_BV : S_F3;
            end
            S_F3: state_d = S_F4;
            S_F4: state_d = S_F5;
            S_F5: state_d = S_F6;
            S_F6: state_d = S_F7;
            S_F7: state_d = S_F8;
            S_F8: begin
              if (j_q == last_q - AW'(1)) state_d = S_BV;
              else begin
                j_d = j_q + AW'(1);
                state_d = S_F3;
              end
            end
            S_BV: begin
              j_d = last_q - AW'(2);
              state_d = (last_q == AW'(2)) ? S_E0 : S_G0;
            end
            S_G0: state_d = S_G1;
            S_G1: begin
              if (j_q == AW'(1)) state_d = S_E0;
              else begin
                j_d = j_q - AW'(1);
                state_d = S_G0;
              end
            end
            S_E0: state_d = S_E1;
            S_E1: begin
              if (step_q == n_q - 12'd1) state_d = S_FIN;
              else begin
                step_d  = step_q + 12'd1;
                state_d = S_K;
              end
            end
            S_FIN: state_d = S_OUT;
            default: state_d = S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_ADDR;
      j_q     <= '0;
      m_q     <= '0;
      last_q  <= '0;
      n_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      j_q     <= j_d;
      m_q     <= m_d;
      last_q  <= last_d;
      n_q     <= n_d;
      step_q  <= step_d;
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_OUT;

  done_single_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");
  accept_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  done_in_wait_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.done |-> (ph_q == PH_WAIT))
    else $error("datapath completion outside wait phase");
  go_once_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.go |=> !cmd_o.go)
    else $error("operation issued twice");
endmodule
`default_nettype wire

>>> hw/rtl/crank_nicolson_option_pricer.sv
// crank_nicolson_option_pricer: top level of the Crank-Nicolson European option
// pricer. Depends on cnop_pkg, cnop_ctrl, cnop_dp (with cnop_mul, cnop_div).
`default_nettype none
// Prices one European call or put per item on a log-price grid of 2M+1 nodes,
// all values signed Q24.24 in 48 bits with saturation. Load the seven
// configuration registers (spot, strike, exp(dx), exp(-r dt), coefficients a,
// b, c) while the block is idle, then pulse start with is_put_i, time_steps_i
// (N) and half_width_i (M; 0 counts as 1, above MAX_HALF_WIDTH is clamped).
// An item is taken when start is high and busy is low; busy stays high until
// the result. The price and status appear for exactly one cycle with done_o
// high and cannot be held off, so the receiver must take them in that cycle.
// status_o is 1 if any division by zero occurred. Items run one at a time;
// every datapath operation passes through an address phase, an issue phase
// and a wait for its unit (a multiply does 48x16 bits per cycle, a divide is
// bit-serial over 72 quotient bits). Per inner node, a time step takes 3
// multiplies and 2 adds for the right-hand side, 2 multiplies, 2 subtracts
// and 2 divides in the forward sweep, and a multiply and a subtract in back
// substitution; the divides dominate the run time of an item.
module crank_nicolson_option_pricer #(
  parameter int MAX_HALF_WIDTH = cnop_pkg::MAX_HALF_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          is_put_i,
  input  wire logic [11:0]                   time_steps_i,
  input  wire logic [7:0]                    half_width_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_idx_i,
  input  wire logic [cnop_pkg::W-1:0]        cfg_wdata_i,
  output logic                               done_o,
  output logic signed [cnop_pkg::W-1:0]      option_price_o,
  output logic                               status_o
);
  localparam int AW = $clog2(2 * MAX_HALF_WIDTH + 1);

  cnop_pkg::cmd_t    cmd;
  cnop_pkg::dp_sts_t sts;
  logic [AW-1:0]     addr;

  // sequencer: one datapath operation at a time
  cnop_ctrl #(.MAX_HALF_WIDTH(MAX_HALF_WIDTH)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .time_steps_i (time_steps_i),
    .half_width_i (half_width_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .addr_o       (addr),
    .done_o       (done_o)
  );

  // datapath: config, rows in memory, shared multiplier and divider
  cnop_dp #(.MAX_HALF_WIDTH(MAX_HALF_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .is_put_i    (is_put_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (sts),
    .price_o     (option_price_o),
    .status_o    (status_o)
  );
endmodule
`default_nettype wire

>>> tb/sv/crank_nicolson_option_pricer_tb.sv
// crank_nicolson_option_pricer_tb: self-checking bench for the option pricer.
// Depends on cnop_pkg and the crank_nicolson_option_pricer RTL only.
`default_nettype none
module crank_nicolson_option_pricer_tb;

  localparam int     W    = cnop_pkg::W;
  localparam longint QMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint QMIN = -64'sh8000_0000_0000;
  localparam longint QONE = 64'sd1 << 24;
  localparam int     ROW  = 257;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic is_put = 1'b0;
  logic [11:0] time_steps = '0;
  logic [7:0] half_width = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = cnop_pkg::CFG_SPOT;
  logic [W-1:0] cfg_wdata = '0;
  logic done;
  logic signed [W-1:0] option_price;
  logic status;

  crank_nicolson_option_pricer u_top (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .is_put_i(is_put), .time_steps_i(time_steps), .half_width_i(half_width),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .done_o(done), .option_price_o(option_price), .status_o(status)
  );

  // bench copy of the register file
  longint spot_q, strike_q, ratio_q, disc_q, cl_q, cc_q, cu_q;
  // working rows of the pricing predictor
  longint val_row [ROW];
  longint fac_row [ROW];
  longint rhs_row [ROW];
  logic   zero_div;

  typedef struct {
    logic [W-1:0] price;
    logic         status;
  } quote_t;
  quote_t pending_quotes[$];

  int mismatches = 0;
  int quotes_seen = 0;
  int items_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("crank_nicolson_option_pricer verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- Q24.24 math
  function automatic longint sat48(longint v);
    return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
  endfunction

  function automatic longint q_add(longint a, longint b);
    return sat48(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return sat48(a - b);
  endfunction

  // magnitude, sign, saturate (48-bit magnitude of MINV is 2^47)
  function automatic longint q_sign(logic neg, logic [127:0] r);
    if (neg) return (r > 128'h8000_0000_0000) ? QMIN : -longint'(r[63:0]);
    return (r > 128'h7FFF_FFFF_FFFF) ? QMAX : longint'(r[63:0]);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] ma, mb;
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    return q_sign((a < 0) != (b < 0), (ma * mb) >> 24);
  endfunction

  function automatic longint q_div(longint a, longint b);
    logic [127:0] ma, mb;
    if (b == 0) begin
      zero_div = 1'b1;
      return a > 0 ? QMAX : (a < 0 ? QMIN : 0);
    end
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    return q_sign((a < 0) != (b < 0), (ma << 24) / mb);
  endfunction

  function automatic longint payoff_at(logic put, longint s);
    longint v;
    v = put ? q_sub(strike_q, s) : q_sub(s, strike_q);
    return v > 0 ? v : 0;
  endfunction

  // full backward induction for one item; returns the centre value and flag
  function automatic quote_t price_option(logic put, int n_steps, int m_in);
    int m, last;
    longint s, inv, one_pb, diag, low_n, upp_n, top_s, k_disc, lo_b, hi_b, piv, r;
    quote_t q;
    m = m_in < 1 ? 1 : (m_in > 128 ? 128 : m_in);
    last = 2 * m;
    zero_div = 1'b0;
    s = spot_q;
    val_row[m] = payoff_at(put, s);
    for (int j = m + 1; j <= last; j++) begin
      s = q_mul(s, ratio_q);
      val_row[j] = payoff_at(put, s);
    end
    top_s = s;
    inv = q_div(QONE, ratio_q);
    s = spot_q;
    for (int j = m - 1; j >= 0; j--) begin
      s = q_mul(s, inv);
      val_row[j] = payoff_at(put, s);
    end
    one_pb = q_add(QONE, cc_q);
    diag = q_sub(QONE, cc_q);
    low_n = sat48(-cl_q);
    upp_n = sat48(-cu_q);
    k_disc = strike_q;
    for (int st = 0; st < n_steps; st++) begin
      k_disc = q_mul(k_disc, disc_q);
      for (int j = 1; j < last; j++) begin
        r = q_mul(cl_q, val_row[j-1]);
        r = q_add(r, q_mul(one_pb, val_row[j]));
        rhs_row[j] = q_add(r, q_mul(cu_q, val_row[j+1]));
      end
      lo_b = put ? k_disc : 0;
      hi_b = put ? 0 : q_sub(top_s, k_disc);
      rhs_row[1] = q_sub(rhs_row[1], q_mul(low_n, lo_b));
      rhs_row[last-1] = q_sub(rhs_row[last-1], q_mul(upp_n, hi_b));
      // Thomas: forward elimination then back substitution
      fac_row[1] = q_div(upp_n, diag);
      rhs_row[1] = q_div(rhs_row[1], diag);
      for (int j = 2; j < last; j++) begin
        piv = q_sub(diag, q_mul(low_n, fac_row[j-1]));
        fac_row[j] = q_div(upp_n, piv);
        rhs_row[j] = q_div(q_sub(rhs_row[j], q_mul(low_n, rhs_row[j-1])), piv);
      end
      val_row[last-1] = rhs_row[last-1];
      for (int j = last - 2; j >= 1; j--)
        val_row[j] = q_sub(rhs_row[j], q_mul(fac_row[j], val_row[j+1]));
      val_row[0] = lo_b;
      val_row[last] = hi_b;
    end
    q.price = val_row[m][W-1:0];
    q.status = zero_div;
    return q;
  endfunction

  // ------------------------------------------------------------ result checking
  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin
    if (rst_n && done) begin
      quote_t want;
      quotes_seen++;
      if (pending_quotes.size() == 0) begin
        report_mismatch("unexpected quote", option_price, '0);
      end else begin
        want = pending_quotes.pop_front();
        if (option_price !== want.price) report_mismatch("option_price", option_price, want.price);
        if (status !== want.status) report_mismatch("status", W'(status), W'(want.status));
      end
    end
  end

  // ------------------------------------------------------------------- drivers
  task automatic write_reg(logic [2:0] idx, logic [W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    case (idx)
      cnop_pkg::CFG_SPOT:   spot_q = longint'(v[46:0]);
      cnop_pkg::CFG_STRIKE: strike_q = longint'(v[46:0]);
      cnop_pkg::CFG_RATIO:  ratio_q = longint'(v[46:0]);
      cnop_pkg::CFG_DISC:   disc_q = longint'(v[24:0]);
      cnop_pkg::CFG_CL:     cl_q = longint'($signed(v));
      cnop_pkg::CFG_CC:     cc_q = longint'($signed(v));
      default:              cu_q = longint'($signed(v));
    endcase
  endtask

  task automatic load_regs(logic [W-1:0] sp, logic [W-1:0] k, logic [W-1:0] g,
                           logic [W-1:0] d, logic [W-1:0] a, logic [W-1:0] b,
                           logic [W-1:0] c);
    write_reg(cnop_pkg::CFG_SPOT, sp);
    write_reg(cnop_pkg::CFG_STRIKE, k);
    write_reg(cnop_pkg::CFG_RATIO, g);
    write_reg(cnop_pkg::CFG_DISC, d);
    write_reg(cnop_pkg::CFG_CL, a);
    write_reg(cnop_pkg::CFG_CC, b);
    write_reg(cnop_pkg::CFG_CU, c);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block must be idle: every quote back, then a short settle
  task automatic drain();
    while (pending_quotes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // start stays high until the edge that takes the item
  task automatic send_item(logic put, int n, int m);
    @(posedge clk);
    start <= 1'b1;
    is_put <= put;
    time_steps <= 12'(n);
    half_width <= 8'(m);
    do @(posedge clk); while (busy);
    pending_quotes.push_back(price_option(put, n, m));
    items_sent++;
    start <= 1'b0;
  endtask

  // random Q value biased toward the edges of a field
  function automatic logic [W-1:0] pick_val(logic [W-1:0] lo, logic [W-1:0] hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return W'({$urandom, $urandom}) & hi;
      default: return W'($urandom_range(0, 32'h0300_0000));
    endcase
  endfunction

  function automatic logic [W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return cnop_pkg::MAXV;
      1: return cnop_pkg::MINV;
      2: return W'({$urandom, $urandom});
      default: return W'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endcase
  endfunction

  // directed rows; typed expectation only where obvious
  typedef struct {
    logic put;
    int n;
    int m;
    logic typed;
    logic [W-1:0] price;
    logic st;
  } row_t;

  row_t plan[$];

  initial begin
    int gap;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // register file at reset values: zero spot and strike give a zero quote
    spot_q = 0; strike_q = 0; ratio_q = QONE; disc_q = QONE;
    cl_q = 0; cc_q = 0; cu_q = 0;
    plan = '{
      '{1'b0, 0, 1, 1'b1, '0, 1'b0},
      '{1'b1, 0, 0, 1'b1, '0, 1'b0},
      '{1'b0, 1, 255, 1'b0, '0, 1'b0},
      '{1'b1, 4095, 1, 1'b0, '0, 1'b0}
    };
    foreach (plan[i]) begin
      send_item(plan[i].put, plan[i].n, plan[i].m);
      if (plan[i].typed) pending_quotes[$] = '{plan[i].price, plan[i].st};
    end
    drain();

    // textbook-like setup: S = K = 100, a = c = 0.2, b = -0.4
    load_regs(48'd100 << 24, 48'd100 << 24, 48'd17637383, 48'd16760439,
              48'h33_3333, -48'sh66_6666, 48'h33_3333);
    plan = '{
      '{1'b0, 0, 128, 1'b0, '0, 1'b0}, '{1'b1, 0, 200, 1'b0, '0, 1'b0},
      '{1'b0, 3, 4, 1'b0, '0, 1'b0}, '{1'b1, 3, 4, 1'b0, '0, 1'b0},
      '{1'b0, 2, 1, 1'b0, '0, 1'b0}, '{1'b1, 1, 7, 1'b0, '0, 1'b0}
    };
    foreach (plan[i]) send_item(plan[i].put, plan[i].n, plan[i].m);
    drain();

    // zero ratio: its inverse divides by zero, status must rise
    load_regs(48'd100 << 24, 48'd90 << 24, '0, '0, cnop_pkg::MAXV, cnop_pkg::MINV,
              cnop_pkg::MAXV);
    send_item(1'b0, 0, 2);
    send_item(1'b1, 2, 3);
    drain();

    // b = 1.0 makes the diagonal zero: the sweep divisions by the diagonal saturate
    load_regs(48'h7FFF_FFFF_FFFF, '0, 48'h7FFF_FFFF_FFFF, 48'h100_0000,
              cnop_pkg::MINV, 48'h100_0000, cnop_pkg::MINV);
    send_item(1'b0, 1, 2);
    send_item(1'b1, 1, 2);
    drain();

    // random phases: fresh registers, bursts of items with idle gaps
    for (int ph = 0; ph < 4; ph++) begin
      load_regs(pick_val('0, 48'h7FFF_FFFF_FFFF), pick_val('0, 48'h7FFF_FFFF_FFFF),
                pick_val('0, 48'h7FFF_FFFF_FFFF), pick_val('0, 48'h100_0000),
                pick_coef(), pick_coef(), pick_coef());
      for (int k = 0; k < 22; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 40);
          repeat (gap) @(posedge clk);
        end
        if ($urandom_range(0, 14) == 0)
          send_item(1'($urandom_range(0, 1)), int'($urandom_range(0, 1)),
                    int'($urandom_range(0, 255)));
        else
          send_item(1'($urandom_range(0, 1)), int'($urandom_range(0, 3)),
                    int'($urandom_range(0, 5)));
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d items, %0d quotes over reset, fixed and random register sets",
             items_sent, quotes_seen);
    if (mismatches == 0 && pending_quotes.size() == 0) begin
      $display("crank_nicolson_option_pricer verification clean");
    end else begin
      $display("crank_nicolson_option_pricer verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
